// ===== design/sdpg_pkg.sv =====
// shared types, register codes and constants of the stereo distance pan gain unit
// no dependencies
package sdpg_pkg;

   typedef struct packed {
      logic [31:0] listener_x;
      logic [31:0] listener_y;
      logic [31:0] listener_z;
      logic [31:0] right_x;
      logic [31:0] right_y;
      logic [31:0] right_z;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_LISTENER_X = 3'd0,
      REG_LISTENER_Y = 3'd1,
      REG_LISTENER_Z = 3'd2,
      REG_RIGHT_X    = 3'd3,
      REG_RIGHT_Y    = 3'd4,
      REG_RIGHT_Z    = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ATT_FULL = 2'd0,
      ATT_ZERO = 2'd1,
      ATT_DIV  = 2'd2
   } att_mode_type;

   typedef struct packed {
      logic        bypass;
      logic [15:0] volume;
      logic [31:0] min_distance;
      logic [31:0] max_distance;
   } dist_tag_type;

   typedef struct packed {
      dist_tag_type info;
      logic [65:0]  sum_sq;
      logic [63:0]  den_sq;
      logic [32:0]  dot;
   } front_out_type;

   typedef struct packed {
      logic         bypass;
      logic [15:0]  volume;
      att_mode_type mode;
   } att_tag_type;

   typedef struct packed {
      logic enable;
      logic negative;
   } pan_tag_type;

   typedef struct packed {
      logic        bypass;
      logic [15:0] volume;
      logic [16:0] att;
      logic [16:0] npan;
   } gain_in_type;

   typedef struct packed {
      logic [15:0] volume;
      logic [16:0] att;
   } gain_tag_type;

   localparam logic [16:0] UNITY        = 17'd65536;
   localparam logic [32:0] PAN_MIN_DIST = 33'd66;
   localparam int          DIST_ROOT_W  = 33;
   localparam int          GAIN_ROOT_W  = 17;
   localparam int          QUOT_W       = 17;
   localparam int          DEN_W        = 32;

   // shift that brings a magnitude down to at most 15 bits
   function automatic logic [4:0] reduce_shift(input logic [31:0] m);
      logic [4:0] s;
      s = 5'd0;
      for (int i = 15; i < 32; i++) begin
         if (m[i]) begin
            s = 5'(i - 14);
         end
      end
      return s;
   endfunction

endpackage

// ===== design/sdpg_isqrt.sv =====
// pipelined integer square root, one result bit per stage, with a tag that travels alongside
// depends on nothing
module sdpg_isqrt #(
   parameter int ROOT_W = 33,
   parameter int TAG_W  = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   radicand,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     root,
   output logic [TAG_W-1:0]      out_tag
);

   localparam int RAD_W = 2 * ROOT_W;

   logic [RAD_W-1:0] rem_ff   [ROOT_W];
   logic [RAD_W-1:0] acc_ff   [ROOT_W];
   logic [TAG_W-1:0] tag_ff   [ROOT_W];
   logic             valid_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RAD_W-1:0] rem_prev;
      logic [RAD_W-1:0] acc_prev;
      logic [TAG_W-1:0] tag_prev;
      logic             valid_prev;
      logic [RAD_W-1:0] bit_val;
      logic [RAD_W:0]   trial;
      logic             take;
      logic [RAD_W-1:0] rem_in;
      logic [RAD_W-1:0] acc_in;

      if (k == 0) begin : g_first
         assign rem_prev   = radicand;
         assign acc_prev   = '0;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign acc_prev   = acc_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign bit_val = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
      assign trial   = {1'b0, acc_prev} + {1'b0, bit_val};
      assign take    = {1'b0, rem_prev} >= trial;
      assign rem_in  = take ? rem_prev - trial[RAD_W-1:0] : rem_prev;
      assign acc_in  = take ? (acc_prev >> 1) + bit_val : acc_prev >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            acc_ff[k] <= acc_in;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = acc_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ===== design/sdpg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient known to fit
// depends on nothing
module sdpg_div #(
   parameter int QUOT_W = 17,
   parameter int DEN_W  = 32,
   parameter int TAG_W  = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [DEN_W+QUOT_W-1:0]   numerator,
   input  logic [DEN_W-1:0]          denominator,
   input  logic [TAG_W-1:0]          in_tag,
   output logic                      out_valid,
   output logic [QUOT_W-1:0]         quotient,
   output logic [TAG_W-1:0]          out_tag
);

   logic [DEN_W-1:0]  rem_ff   [QUOT_W];
   logic [QUOT_W-1:0] low_ff   [QUOT_W];
   logic [QUOT_W-1:0] quo_ff   [QUOT_W];
   logic [DEN_W-1:0]  den_ff   [QUOT_W];
   logic [TAG_W-1:0]  tag_ff   [QUOT_W];
   logic              valid_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic [DEN_W-1:0]  rem_prev;
      logic [QUOT_W-1:0] low_prev;
      logic [QUOT_W-1:0] quo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic              valid_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              take;
      logic [DEN_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_prev   = numerator[DEN_W+QUOT_W-1:QUOT_W];
         assign low_prev   = numerator[QUOT_W-1:0];
         assign quo_prev   = '0;
         assign den_prev   = denominator;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial  = {rem_prev, low_prev[QUOT_W-1]};
      assign diff   = trial - {1'b0, den_prev};
      assign take   = trial >= {1'b0, den_prev};
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= {low_prev[QUOT_W-2:0], 1'b0};
            quo_ff[k] <= {quo_prev[QUOT_W-2:0], take};
            den_ff[k] <= den_prev;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign quotient  = quo_ff[QUOT_W-1];
   assign out_tag   = tag_ff[QUOT_W-1];

endmodule

// ===== design/sdpg_front.sv =====
// front stages: offsets, squares, vector reduction, dot product and squared norm product
// depends on sdpg_pkg
module sdpg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [31:0]            source_x,
   input  logic [31:0]            source_y,
   input  logic [31:0]            source_z,
   input  sdpg_pkg::dist_tag_type in_info,
   input  sdpg_pkg::cfg_type      cfg,
   output logic                   out_valid,
   output sdpg_pkg::front_out_type out_data
);

   logic [31:0] src [3];
   logic [31:0] lis [3];
   logic [31:0] rgt [3];

   assign src[0] = source_x;
   assign src[1] = source_y;
   assign src[2] = source_z;
   assign lis[0] = cfg.listener_x;
   assign lis[1] = cfg.listener_y;
   assign lis[2] = cfg.listener_z;
   assign rgt[0] = cfg.right_x;
   assign rgt[1] = cfg.right_y;
   assign rgt[2] = cfg.right_z;

   // stage 1: offsets
   logic                   v1_ff;
   sdpg_pkg::dist_tag_type t1_ff;
   logic [31:0]            dmag1_ff [3];
   logic                   dneg1_ff [3];
   logic [31:0]            dmag1_in [3];
   logic                   dneg1_in [3];

   always_comb begin
      logic [32:0] d;
      logic [32:0] m;
      for (int i = 0; i < 3; i++) begin
         d = {src[i][31], src[i]} - {lis[i][31], lis[i]};
         m = d[32] ? (~d + 33'd1) : d;
         dmag1_in[i] = m[31:0];
         dneg1_in[i] = d[32];
      end
   end

   // stage 2: squares and shift for the offset vector
   logic                   v2_ff;
   sdpg_pkg::dist_tag_type t2_ff;
   logic [63:0]            sq2_ff   [3];
   logic [31:0]            dmag2_ff [3];
   logic                   dneg2_ff [3];
   logic [4:0]             shd2_ff;

   // stage 3: sum of squares and reduced vectors
   logic                   v3_ff;
   sdpg_pkg::dist_tag_type t3_ff;
   logic [65:0]            ssq3_ff;
   logic [14:0]            dq3_ff [3];
   logic                   dn3_ff [3];
   logic [14:0]            rq3_ff [3];
   logic                   rn3_ff [3];
   logic [14:0]            rq3_in [3];
   logic                   rn3_in [3];

   always_comb begin
      logic [31:0] rmag [3];
      logic [4:0]  shr;
      for (int i = 0; i < 3; i++) begin
         rmag[i] = rgt[i][31] ? (~rgt[i] + 32'd1) : rgt[i];
      end
      shr = sdpg_pkg::reduce_shift(rmag[0] | rmag[1] | rmag[2]);
      for (int i = 0; i < 3; i++) begin
         rq3_in[i] = 15'(rmag[i] >> shr);
         rn3_in[i] = rgt[i][31];
      end
   end

   // stage 4: products
   logic                   v4_ff;
   sdpg_pkg::dist_tag_type t4_ff;
   logic [65:0]            ssq4_ff;
   logic signed [31:0]     dp4_ff  [3];
   logic [29:0]            ndt4_ff [3];
   logic [29:0]            nrt4_ff [3];
   logic signed [15:0]     dr4     [3];
   logic signed [15:0]     rr4     [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dr4[i] = dn3_ff[i] ? -$signed({1'b0, dq3_ff[i]}) : $signed({1'b0, dq3_ff[i]});
         rr4[i] = rn3_ff[i] ? -$signed({1'b0, rq3_ff[i]}) : $signed({1'b0, rq3_ff[i]});
      end
   end

   // stage 5: sums
   logic                   v5_ff;
   sdpg_pkg::dist_tag_type t5_ff;
   logic [65:0]            ssq5_ff;
   logic [32:0]            dot5_ff;
   logic [31:0]            nd5_ff;
   logic [31:0]            nr5_ff;

   // stage 6: product of the squared norms
   logic                   v6_ff;
   sdpg_pkg::dist_tag_type t6_ff;
   logic [65:0]            ssq6_ff;
   logic [32:0]            dot6_ff;
   logic [63:0]            den6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= in_info;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= t4_ff;
         t6_ff <= t5_ff;
         shd2_ff <= sdpg_pkg::reduce_shift(dmag1_ff[0] | dmag1_ff[1] | dmag1_ff[2]);
         ssq3_ff <= {2'b00, sq2_ff[0]} + {2'b00, sq2_ff[1]} + {2'b00, sq2_ff[2]};
         ssq4_ff <= ssq3_ff;
         ssq5_ff <= ssq4_ff;
         ssq6_ff <= ssq5_ff;
         for (int i = 0; i < 3; i++) begin
            dmag1_ff[i] <= dmag1_in[i];
            dneg1_ff[i] <= dneg1_in[i];
            sq2_ff[i]   <= dmag1_ff[i] * dmag1_ff[i];
            dmag2_ff[i] <= dmag1_ff[i];
            dneg2_ff[i] <= dneg1_ff[i];
            dq3_ff[i]   <= 15'(dmag2_ff[i] >> shd2_ff);
            dn3_ff[i]   <= dneg2_ff[i];
            rq3_ff[i]   <= rq3_in[i];
            rn3_ff[i]   <= rn3_in[i];
            dp4_ff[i]   <= dr4[i] * rr4[i];
            ndt4_ff[i]  <= dq3_ff[i] * dq3_ff[i];
            nrt4_ff[i]  <= rq3_ff[i] * rq3_ff[i];
         end
         dot5_ff <= {dp4_ff[0][31], dp4_ff[0]} + {dp4_ff[1][31], dp4_ff[1]}
                    + {dp4_ff[2][31], dp4_ff[2]};
         nd5_ff  <= {2'b00, ndt4_ff[0]} + {2'b00, ndt4_ff[1]} + {2'b00, ndt4_ff[2]};
         nr5_ff  <= {2'b00, nrt4_ff[0]} + {2'b00, nrt4_ff[1]} + {2'b00, nrt4_ff[2]};
         dot6_ff <= dot5_ff;
         den6_ff <= nd5_ff * nr5_ff;
      end
   end

   assign out_valid       = v6_ff;
   assign out_data.info   = t6_ff;
   assign out_data.sum_sq = ssq6_ff;
   assign out_data.den_sq = den6_ff;
   assign out_data.dot    = dot6_ff;

endmodule

// ===== design/sdpg_gain.sv =====
// back stages: square-root pan law, volume times attenuation times pan, saturation
// depends on sdpg_pkg and sdpg_isqrt
module sdpg_gain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  sdpg_pkg::gain_in_type in_data,
   output logic                  out_valid,
   output logic [15:0]           left_gain,
   output logic [15:0]           right_gain
);

   localparam int RAD_W = 2 * sdpg_pkg::GAIN_ROOT_W;

   logic                       p2_valid_ff;
   logic [RAD_W-1:0]           rad_l_ff;
   logic [RAD_W-1:0]           rad_r_ff;
   sdpg_pkg::gain_tag_type     p2_tag_ff;
   logic                       p2_bypass_ff;

   logic                              sq_valid_l;
   logic                              sq_valid_r;
   logic [sdpg_pkg::GAIN_ROOT_W-1:0]  sq_l;
   logic [sdpg_pkg::GAIN_ROOT_W-1:0]  sq_r;
   sdpg_pkg::gain_tag_type            sq_tag;
   logic                              sq_bypass;

   logic        g1_valid_ff;
   logic [32:0] g1_va_ff;
   logic [16:0] g1_sl_ff;
   logic [16:0] g1_sr_ff;
   logic        g1_bypass_ff;
   logic [15:0] g1_vol_ff;

   logic        g2_valid_ff;
   logic [49:0] g2_pl_ff;
   logic [49:0] g2_pr_ff;
   logic        g2_bypass_ff;
   logic [15:0] g2_vol_ff;

   logic        out_valid_ff;
   logic [15:0] left_ff;
   logic [15:0] right_ff;
   logic [15:0] left_in;
   logic [15:0] right_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff  <= 1'b0;
         g1_valid_ff  <= 1'b0;
         g2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff  <= in_valid;
         g1_valid_ff  <= sq_valid_l & sq_valid_r;
         g2_valid_ff  <= g1_valid_ff;
         out_valid_ff <= g2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_l_ff         <= {1'b0, sdpg_pkg::UNITY - in_data.npan, 16'd0};
         rad_r_ff         <= {1'b0, in_data.npan, 16'd0};
         p2_tag_ff.volume <= in_data.volume;
         p2_tag_ff.att    <= in_data.att;
         p2_bypass_ff     <= in_data.bypass;
         g1_va_ff         <= sq_tag.volume * sq_tag.att;
         g1_sl_ff         <= sq_l;
         g1_sr_ff         <= sq_r;
         g1_bypass_ff     <= sq_bypass;
         g1_vol_ff        <= sq_tag.volume;
         g2_pl_ff         <= g1_va_ff * g1_sl_ff;
         g2_pr_ff         <= g1_va_ff * g1_sr_ff;
         g2_bypass_ff     <= g1_bypass_ff;
         g2_vol_ff        <= g1_vol_ff;
         left_ff          <= left_in;
         right_ff         <= right_in;
      end
   end

   sdpg_isqrt #(
      .ROOT_W (sdpg_pkg::GAIN_ROOT_W),
      .TAG_W  ($bits(sdpg_pkg::gain_tag_type))
   ) u_sqrt_left (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .radicand  (rad_l_ff),
      .in_tag    (p2_tag_ff),
      .out_valid (sq_valid_l),
      .root      (sq_l),
      .out_tag   (sq_tag)
   );

   sdpg_isqrt #(
      .ROOT_W (sdpg_pkg::GAIN_ROOT_W),
      .TAG_W  (1)
   ) u_sqrt_right (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .radicand  (rad_r_ff),
      .in_tag    (p2_bypass_ff),
      .out_valid (sq_valid_r),
      .root      (sq_r),
      .out_tag   (sq_bypass)
   );

   // saturate to 16 bits, plain volume for flat sources
   always_comb begin
      if (g2_bypass_ff) begin
         left_in  = g2_vol_ff;
         right_in = g2_vol_ff;
      end else begin
         left_in  = (|g2_pl_ff[49:48]) ? 16'hFFFF : g2_pl_ff[47:32];
         right_in = (|g2_pr_ff[49:48]) ? 16'hFFFF : g2_pr_ff[47:32];
      end
   end

   assign out_valid  = out_valid_ff;
   assign left_gain  = left_ff;
   assign right_gain = right_ff;

endmodule

// ===== design/stereo_distance_pan_gain_unit.sv =====
// top level: register file, distance and norm roots, attenuation and pan dividers
// depends on sdpg_pkg, sdpg_front, sdpg_isqrt, sdpg_div, sdpg_gain
//
//   channel   ports                         direction
//   request   req_valid/req_ready, req_*    in
//   response  rsp_valid/rsp_ready, rsp_*    out
//   csr       csr_psel ... csr_pready       register access
//
// one request per cycle unless a waiting response holds the pipeline
// the deepest parts are the 33-stage distance root, 17-stage dividers and 17-stage pan roots
// the whole pipeline holds while a response waits, so nothing is dropped or repeated
// synchronous reset clears valid bits and loads the register defaults
module stereo_distance_pan_gain_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_source_x,
   input  logic [31:0] req_source_y,
   input  logic [31:0] req_source_z,
   input  logic [15:0] req_volume,
   input  logic [31:0] req_min_distance,
   input  logic [31:0] req_max_distance,
   input  logic        req_is_3d,
   input  logic        req_position_known,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_left_gain,
   output logic [15:0] rsp_right_gain,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // registers
   logic [31:0] listener_x_ff;
   logic [31:0] listener_y_ff;
   logic [31:0] listener_z_ff;
   logic [31:0] right_x_ff;
   logic [31:0] right_y_ff;
   logic [31:0] right_z_ff;
   logic        csr_write;
   sdpg_pkg::reg_index_type csr_index;
   sdpg_pkg::cfg_type       cfg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = sdpg_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         listener_x_ff <= 32'd0;
         listener_y_ff <= 32'd0;
         listener_z_ff <= 32'd0;
         right_x_ff    <= 32'd65536;
         right_y_ff    <= 32'd0;
         right_z_ff    <= 32'd0;
      end else if (csr_write) begin
         case (csr_index)
            sdpg_pkg::REG_LISTENER_X: listener_x_ff <= csr_pwdata;
            sdpg_pkg::REG_LISTENER_Y: listener_y_ff <= csr_pwdata;
            sdpg_pkg::REG_LISTENER_Z: listener_z_ff <= csr_pwdata;
            sdpg_pkg::REG_RIGHT_X:    right_x_ff    <= csr_pwdata;
            sdpg_pkg::REG_RIGHT_Y:    right_y_ff    <= csr_pwdata;
            sdpg_pkg::REG_RIGHT_Z:    right_z_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sdpg_pkg::REG_LISTENER_X: csr_prdata = listener_x_ff;
         sdpg_pkg::REG_LISTENER_Y: csr_prdata = listener_y_ff;
         sdpg_pkg::REG_LISTENER_Z: csr_prdata = listener_z_ff;
         sdpg_pkg::REG_RIGHT_X:    csr_prdata = right_x_ff;
         sdpg_pkg::REG_RIGHT_Y:    csr_prdata = right_y_ff;
         sdpg_pkg::REG_RIGHT_Z:    csr_prdata = right_z_ff;
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign cfg.listener_x = listener_x_ff;
   assign cfg.listener_y = listener_y_ff;
   assign cfg.listener_z = listener_z_ff;
   assign cfg.right_x    = right_x_ff;
   assign cfg.right_y    = right_y_ff;
   assign cfg.right_z    = right_z_ff;

   // front stages
   sdpg_pkg::dist_tag_type  req_info;
   logic                    front_valid;
   sdpg_pkg::front_out_type front_data;

   assign req_info.bypass       = !(req_is_3d && req_position_known);
   assign req_info.volume       = req_volume;
   assign req_info.min_distance = req_min_distance;
   assign req_info.max_distance = req_max_distance;

   sdpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid & req_ready),
      .source_x  (req_source_x),
      .source_y  (req_source_y),
      .source_z  (req_source_z),
      .in_info   (req_info),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // distance root and norm root side by side
   logic                                dist_valid;
   logic [sdpg_pkg::DIST_ROOT_W-1:0]    dist_root;
   sdpg_pkg::dist_tag_type              dist_info;
   logic                                norm_valid;
   logic [sdpg_pkg::DIST_ROOT_W-1:0]    norm;
   logic [32:0]                         norm_dot;

   sdpg_isqrt #(
      .ROOT_W (sdpg_pkg::DIST_ROOT_W),
      .TAG_W  ($bits(sdpg_pkg::dist_tag_type))
   ) u_sqrt_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .radicand  (front_data.sum_sq),
      .in_tag    (front_data.info),
      .out_valid (dist_valid),
      .root      (dist_root),
      .out_tag   (dist_info)
   );

   sdpg_isqrt #(
      .ROOT_W (sdpg_pkg::DIST_ROOT_W),
      .TAG_W  (33)
   ) u_sqrt_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .radicand  ({2'b00, front_data.den_sq}),
      .in_tag    (front_data.dot),
      .out_valid (norm_valid),
      .root      (norm),
      .out_tag   (norm_dot)
   );

   // attenuation mode and pan operands
   logic                      m1_valid_ff;
   sdpg_pkg::att_tag_type     m1_att_ff;
   logic [31:0]               m1_att_num_ff;
   logic [31:0]               m1_att_den_ff;
   sdpg_pkg::pan_tag_type     m1_pan_ff;
   logic [31:0]               m1_abs_dot_ff;
   logic [31:0]               m1_pan_den_ff;
   sdpg_pkg::att_mode_type    mode_in;
   logic                      right_nonzero;
   logic [32:0]               abs_dot;

   assign right_nonzero = |{right_x_ff, right_y_ff, right_z_ff};
   assign abs_dot       = norm_dot[32] ? (~norm_dot + 33'd1) : norm_dot;

   always_comb begin
      mode_in = sdpg_pkg::ATT_FULL;
      if (dist_root > {1'b0, dist_info.min_distance}
          && dist_info.max_distance > dist_info.min_distance) begin
         if (dist_root >= {1'b0, dist_info.max_distance}) begin
            mode_in = sdpg_pkg::ATT_ZERO;
         end else begin
            mode_in = sdpg_pkg::ATT_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= dist_valid & norm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_att_ff.bypass   <= dist_info.bypass;
         m1_att_ff.volume   <= dist_info.volume;
         m1_att_ff.mode     <= mode_in;
         m1_att_num_ff      <= dist_info.max_distance - dist_root[31:0];
         m1_att_den_ff      <= dist_info.max_distance - dist_info.min_distance;
         m1_pan_ff.enable   <= (dist_root >= sdpg_pkg::PAN_MIN_DIST) && right_nonzero
                               && (norm != '0);
         m1_pan_ff.negative <= norm_dot[32];
         m1_abs_dot_ff      <= abs_dot[31:0];
         m1_pan_den_ff      <= norm[31:0];
      end
   end

   // dividers
   logic                         att_valid;
   logic [sdpg_pkg::QUOT_W-1:0]  att_q;
   sdpg_pkg::att_tag_type        att_tag;
   logic                         pan_valid;
   logic [sdpg_pkg::QUOT_W-1:0]  pan_q;
   sdpg_pkg::pan_tag_type        pan_tag;

   sdpg_div #(
      .QUOT_W (sdpg_pkg::QUOT_W),
      .DEN_W  (sdpg_pkg::DEN_W),
      .TAG_W  ($bits(sdpg_pkg::att_tag_type))
   ) u_div_att (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (m1_valid_ff),
      .numerator   ({1'b0, m1_att_num_ff, 16'd0}),
      .denominator (m1_att_den_ff),
      .in_tag      (m1_att_ff),
      .out_valid   (att_valid),
      .quotient    (att_q),
      .out_tag     (att_tag)
   );

   sdpg_div #(
      .QUOT_W (sdpg_pkg::QUOT_W),
      .DEN_W  (sdpg_pkg::DEN_W),
      .TAG_W  ($bits(sdpg_pkg::pan_tag_type))
   ) u_div_pan (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (m1_valid_ff),
      .numerator   ({1'b0, m1_abs_dot_ff, 16'd0}),
      .denominator (m1_pan_den_ff),
      .in_tag      (m1_pan_ff),
      .out_valid   (pan_valid),
      .quotient    (pan_q),
      .out_tag     (pan_tag)
   );

   // attenuation value and normalised pan
   logic                  p1_valid_ff;
   sdpg_pkg::gain_in_type p1_ff;
   sdpg_pkg::gain_in_type p1_in;
   logic [17:0]           pan_sum;

   always_comb begin
      if (!pan_tag.enable) begin
         pan_sum = {1'b0, sdpg_pkg::UNITY};
      end else if (pan_tag.negative) begin
         pan_sum = {1'b0, sdpg_pkg::UNITY} - {1'b0, pan_q};
      end else begin
         pan_sum = {1'b0, sdpg_pkg::UNITY} + {1'b0, pan_q};
      end
      p1_in.bypass = att_tag.bypass;
      p1_in.volume = att_tag.volume;
      p1_in.npan   = pan_sum[17:1];
      case (att_tag.mode)
         sdpg_pkg::ATT_FULL: p1_in.att = sdpg_pkg::UNITY;
         sdpg_pkg::ATT_ZERO: p1_in.att = 17'd0;
         sdpg_pkg::ATT_DIV:  p1_in.att = att_q;
         default:            p1_in.att = sdpg_pkg::UNITY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= att_valid & pan_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
      end
   end

   sdpg_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (p1_valid_ff),
      .in_data    (p1_ff),
      .out_valid  (rsp_valid),
      .left_gain  (rsp_left_gain),
      .right_gain (rsp_right_gain)
   );

endmodule

// ===== verif/tb_stereo_distance_pan_gain_unit.sv =====
// testbench of the stereo distance pan gain unit: directed and random sources with
// gains checked against an in-bench bit-exact gain calculation
// depends on sdpg_pkg and stereo_distance_pan_gain_unit
module tb_stereo_distance_pan_gain_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
   } gains_type;

   typedef struct packed {
      longint x;
      longint y;
      longint z;
   } vec3_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_source_x;
   logic [31:0] req_source_y;
   logic [31:0] req_source_z;
   logic [15:0] req_volume;
   logic [31:0] req_min_distance;
   logic [31:0] req_max_distance;
   logic        req_is_3d;
   logic        req_position_known;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_left_gain;
   logic [15:0] rsp_right_gain;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [31:0] listener [3];
   logic [31:0] right_dir [3];
   gains_type   gains_due [$];
   int          mismatches;
   int          cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   stereo_distance_pan_gain_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = 64'd0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= x) begin
            r = c;
         end
      end
      return r;
   endfunction

   function automatic vec3_type shrink(input vec3_type v);
      logic [63:0] m;
      logic [63:0] a [3];
      int          sh;
      vec3_type    o;
      a[0] = v.x < 0 ? -v.x : v.x;
      a[1] = v.y < 0 ? -v.y : v.y;
      a[2] = v.z < 0 ? -v.z : v.z;
      m = a[0];
      if (a[1] > m) m = a[1];
      if (a[2] > m) m = a[2];
      sh = 0;
      while ((m >> sh) > 64'd32767) sh++;
      o.x = v.x < 0 ? -longint'(a[0] >> sh) : longint'(a[0] >> sh);
      o.y = v.y < 0 ? -longint'(a[1] >> sh) : longint'(a[1] >> sh);
      o.z = v.z < 0 ? -longint'(a[2] >> sh) : longint'(a[2] >> sh);
      return o;
   endfunction

   function automatic gains_type predict_gains(input logic [31:0] sx, input logic [31:0] sy,
                                               input logic [31:0] sz, input logic [15:0] vol,
                                               input logic [31:0] dmin, input logic [31:0] dmax,
                                               input logic is3d, input logic known);
      vec3_type    d;
      vec3_type    r;
      vec3_type    dr;
      vec3_type    rr;
      logic [67:0] sum;
      logic [67:0] mg;
      logic [67:0] root;
      logic [67:0] c;
      logic [63:0] att;
      logic [63:0] nd;
      logic [63:0] nr;
      logic [63:0] den;
      logic [63:0] npan;
      logic [63:0] sl;
      logic [63:0] sr;
      logic [63:0] g;
      longint      dot;
      longint      pan;
      gains_type   res;
      if (!is3d || !known) begin
         res.left = vol;
         res.right = vol;
         return res;
      end
      d.x = longint'($signed(sx)) - longint'($signed(listener[0]));
      d.y = longint'($signed(sy)) - longint'($signed(listener[1]));
      d.z = longint'($signed(sz)) - longint'($signed(listener[2]));
      r.x = longint'($signed(right_dir[0]));
      r.y = longint'($signed(right_dir[1]));
      r.z = longint'($signed(right_dir[2]));
      sum = 68'd0;
      mg = d.x < 0 ? 68'(-d.x) : 68'(d.x);
      sum += mg * mg;
      mg = d.y < 0 ? 68'(-d.y) : 68'(d.y);
      sum += mg * mg;
      mg = d.z < 0 ? 68'(-d.z) : 68'(d.z);
      sum += mg * mg;
      root = 68'd0;
      for (int b = 33; b >= 0; b--) begin
         c = root | (68'd1 << b);
         if (c * c <= sum) begin
            root = c;
         end
      end
      att = 64'd65536;
      if (root > 68'(dmin) && dmax > dmin) begin
         if (root >= 68'(dmax)) begin
            att = 64'd0;
         end else begin
            att = ((64'(dmax) - 64'(root)) << 16) / (64'(dmax) - 64'(dmin));
         end
      end
      pan = 0;
      if (root >= 68'd66 && (r.x != 0 || r.y != 0 || r.z != 0)) begin
         dr = shrink(d);
         rr = shrink(r);
         dot = dr.x * rr.x + dr.y * rr.y + dr.z * rr.z;
         nd = 64'(dr.x * dr.x + dr.y * dr.y + dr.z * dr.z);
         nr = 64'(rr.x * rr.x + rr.y * rr.y + rr.z * rr.z);
         den = root64(nd * nr);
         if (den != 0) begin
            pan = (dot * 65536) / longint'(den);
            if (pan > 65536) pan = 65536;
            if (pan < -65536) pan = -65536;
         end
      end
      npan = 64'(pan + 65536) >> 1;
      sl = root64((64'd65536 - npan) << 16);
      sr = root64(npan << 16);
      g = (64'(vol) * att * sl) >> 32;
      res.left = g > 64'd65535 ? 16'hffff : g[15:0];
      g = (64'(vol) * att * sr) >> 32;
      res.right = g > 64'd65535 ? 16'hffff : g[15:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   // response checker
   always @(posedge clock) begin
      gains_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gains_due.size() == 0) begin
            report_mismatch("unexpected response", rsp_left_gain, 16'd0);
         end else begin
            want = gains_due.pop_front();
            if (rsp_left_gain !== want.left) report_mismatch("left", rsp_left_gain, want.left);
            if (rsp_right_gain !== want.right)
               report_mismatch("right", rsp_right_gain, want.right);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("stereo_distance_pan_gain_unit verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz, input logic [15:0] vol,
                               input logic [31:0] dmin, input logic [31:0] dmax,
                               input logic is3d, input logic known);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_x <= sx;
      req_source_y <= sy;
      req_source_z <= sz;
      req_volume <= vol;
      req_min_distance <= dmin;
      req_max_distance <= dmax;
      req_is_3d <= is3d;
      req_position_known <= known;
      do @(posedge clock); while (!req_ready);
      gains_due.push_back(predict_gains(sx, sy, sz, vol, dmin, dmax, is3d, known));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (gains_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input sdpg_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx <= sdpg_pkg::REG_LISTENER_Z) listener[2'(idx)] = value;
      else right_dir[2'(idx - sdpg_pkg::REG_RIGHT_X)] = value;
   endtask

   task automatic set_listener(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                               input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz);
      write_reg(sdpg_pkg::REG_LISTENER_X, lx);
      write_reg(sdpg_pkg::REG_LISTENER_Y, ly);
      write_reg(sdpg_pkg::REG_LISTENER_Z, lz);
      write_reg(sdpg_pkg::REG_RIGHT_X, rx);
      write_reg(sdpg_pkg::REG_RIGHT_Y, ry);
      write_reg(sdpg_pkg::REG_RIGHT_Z, rz);
   endtask

   task automatic test_flat_sources;
      send_request(32'h1234_0000, 32'h0, 32'h0, 16'hffff, 32'h1_0000, 32'h10_0000, 1'b0, 1'b1);
      send_request(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h0000, 32'h0, 32'h0, 1'b0,
                   1'b0);
      send_request(32'h5_0000, 32'h0, 32'h0, 16'h1000, 32'h0, 32'h10_0000, 1'b1, 1'b0);
      send_request(32'h0, 32'h0, 32'h0, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
   endtask

   task automatic test_spatial_cases;
      // hard right, hard left, centre
      send_request(32'h2_0000, 32'h0, 32'h0, 16'h1000, 32'h1_0000, 32'h10_0000, 1'b1, 1'b1);
      send_request(32'hfffe_0000, 32'h0, 32'h0, 16'hffff, 32'h0, 32'h10_0000, 1'b1, 1'b1);
      send_request(32'h0, 32'h3_0000, 32'h0, 16'hffff, 32'h0, 32'h0, 1'b1, 1'b1);
      // source at the listener, just below and at the pan threshold
      send_request(32'h0, 32'h0, 32'h0, 16'h1000, 32'h0, 32'h10_0000, 1'b1, 1'b1);
      send_request(32'd65, 32'h0, 32'h0, 16'h1000, 32'h0, 32'h10_0000, 1'b1, 1'b1);
      send_request(32'd66, 32'h0, 32'h0, 16'h1000, 32'h0, 32'h10_0000, 1'b1, 1'b1);
      // beyond max, inverted range, equal range
      send_request(32'h20_0000, 32'h0, 32'h0, 16'h1000, 32'h1_0000, 32'h10_0000, 1'b1, 1'b1);
      send_request(32'h8_0000, 32'h0, 32'h0, 16'h1000, 32'h10_0000, 32'h1_0000, 1'b1, 1'b1);
      send_request(32'h8_0000, 32'h0, 32'h0, 16'h1000, 32'h1_0000, 32'h1_0000, 1'b1, 1'b1);
      // widest differences
      send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 32'h0,
                   32'hffff_ffff, 1'b1, 1'b1);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff, 32'h0,
                   32'hffff_ffff, 1'b1, 1'b1);
      drain();
      set_listener(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      // zero right vector
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 16'hffff, 32'h0,
                   32'hffff_ffff, 1'b1, 1'b1);
      send_request(32'h7fff_0000, 32'h8000_0000, 32'h0, 16'h8000, 32'h0, 32'h0, 1'b1, 1'b1);
      drain();
      set_listener(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000);
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 32'h0, 32'hffff_ffff,
                   1'b1, 1'b1);
      send_request(32'h8000_0000, 32'h7fff_0000, 32'h0, 16'h1000, 32'h0, 32'h0, 1'b1, 1'b1);
      drain();
   endtask

   task automatic test_random_sources(input int count);
      logic [31:0] base [3];
      logic [31:0] pos [3];
      logic [31:0] dmin;
      logic [31:0] dmax;
      int          kind;
      int          span;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(9);
         span = $urandom_range(24);
         for (int a = 0; a < 3; a++) begin
            base[a] = listener[a];
            pos[a] = base[a] + $urandom_range(2 << span) - (1 << span);
            if (kind == 8) pos[a] = $urandom();
            if (kind == 9) pos[a] = base[a] + $urandom_range(80) - 40;
         end
         dmin = $urandom() >> $urandom_range(31);
         dmax = $urandom() >> $urandom_range(31);
         if ($urandom_range(3) == 0) dmin = 32'd0;
         if (kind == 0) begin
            send_request(pos[0], pos[1], pos[2], 16'($urandom()), dmin, dmax,
                         1'($urandom_range(1)), 1'b0);
         end else begin
            send_request(pos[0], pos[1], pos[2], 16'($urandom()), dmin, dmax, 1'b1,
                         kind != 1 || $urandom_range(1) != 0);
         end
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_source_x = '0;
      req_source_y = '0;
      req_source_z = '0;
      req_volume = '0;
      req_min_distance = '0;
      req_max_distance = '0;
      req_is_3d = 1'b0;
      req_position_known = 1'b0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      cycles = 0;
      listener = '{32'h0, 32'h0, 32'h0};
      right_dir = '{32'h1_0000, 32'h0, 32'h0};
      send_idle_pct = 11;
      recv_idle_pct = 82;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_flat_sources();
      test_spatial_cases();
      set_listener(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0);
      test_random_sources(150);
      set_listener($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      test_random_sources(150);
      send_idle_pct = 82;
      recv_idle_pct = 11;
      set_listener($urandom() >> 8, $urandom() >> 8, $urandom() >> 8, 32'h0, 32'hffff_0000,
                   32'd1);
      test_random_sources(150);
      set_listener(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff);
      test_random_sources(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_listener($urandom(), $urandom(), $urandom(), $urandom() >> 20, $urandom() >> 20,
                   $urandom() >> 20);
      test_random_sources(175);
      set_listener(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000);
      test_random_sources(150);
      if (mismatches == 0) begin
         $display("stereo_distance_pan_gain_unit verification clean");
      end else begin
         $display("stereo_distance_pan_gain_unit verification failed");
      end
      $finish;
   end

endmodule
